/* design/tpss_pkg.sv */
// Package for the texture page sprite splitter.
// Holds state codes, the span result type, page constants and the depth decode.
// No dependencies.
package tpss_pkg;

    localparam logic [1:0]  DEPTH_4BIT    = 2'd0;
    localparam logic [1:0]  DEPTH_8BIT    = 2'd1;
    localparam logic [3:0]  LOG_PAGE_4BIT = 4'd6;
    localparam logic [3:0]  LOG_PAGE_8BIT = 4'd7;
    localparam logic [3:0]  LOG_PAGE_16   = 4'd8;
    localparam logic [3:0]  LOG_PAGE_LINE = 4'd8;
    localparam logic [10:0] VRAM_WORDS    = 11'd1024;
    localparam logic [9:0]  VRAM_LINES    = 10'd512;
    localparam logic [2:0]  OPAQUE_MODE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_COL
    } t_state;

    typedef struct packed {
        logic [7:0] off;
        logic [8:0] span;
        logic [9:0] base;
    } t_span;

    function automatic logic [3:0] f_page_log(input logic [1:0] depth);
        logic [3:0] lg;
        case (depth)
            DEPTH_4BIT: lg = LOG_PAGE_4BIT;
            DEPTH_8BIT: lg = LOG_PAGE_8BIT;
            default:    lg = LOG_PAGE_16;
        endcase
        return lg;
    endfunction

endpackage

/* design/tpss_span_unit.sv */
// Shared span unit: offset inside a page, page base, and the span to the
// page border clipped to what remains. Used for page rows and page columns.
// Depends on tpss_pkg.
module tpss_span_unit (
    input  logic [9:0]     i_pos,
    input  logic [3:0]     i_log,
    input  logic [10:0]    i_rem,
    output tpss_pkg::t_span o_span
);
    import tpss_pkg::*;

    logic [10:0] w_pw;
    logic [10:0] w_mask;
    logic [7:0]  w_off;
    logic [10:0] w_room;

    assign w_pw   = 11'd1 << i_log;
    assign w_mask = w_pw - 11'd1;
    assign w_off  = i_pos[7:0] & w_mask[7:0];
    assign w_room = w_pw - {3'b000, w_off};

    always_comb begin
        o_span.off  = w_off;
        o_span.base = i_pos & ~w_mask[9:0];
        if (i_rem < w_room) begin
            o_span.span = i_rem[8:0];
        end else begin
            o_span.span = w_room[8:0];
        end
    end

endmodule

/* design/texture_page_sprite_splitter.sv */
// A draw request is cut into one sprite slice per texture page it covers, rows of pages
// top to bottom, pages left to right. Each row of pages gets a setup step, then its
// slices, one per cycle while the output is not stalled; new requests stall until the
// last slice is loaded. One span unit, shared by the row and column steps, sets this
// pace. Empty requests are dropped at accept. An output register holds each slice.
module texture_page_sprite_splitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [9:0]         i_vram_x,
    input  logic [8:0]         i_vram_y,
    input  logic [10:0]        i_width_words,
    input  logic [9:0]         i_height_lines,
    input  logic [1:0]         i_depth,
    input  logic signed [15:0] i_screen_x,
    input  logic signed [15:0] i_screen_y,
    input  logic [2:0]         i_transparency,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_draw_x,
    output logic signed [15:0] o_draw_y,
    output logic [8:0]         o_sprite_width,
    output logic [8:0]         o_sprite_height,
    output logic [7:0]         o_tex_u,
    output logic [7:0]         o_tex_v,
    output logic [9:0]         o_page_x,
    output logic [8:0]         o_page_y,
    output logic [1:0]         o_blend_mode,
    output logic               o_semi_trans,
    output logic               o_last
);
    import tpss_pkg::*;

    t_state      r_state, n_state;
    logic        r_out_valid;

    logic [9:0]  r_vx;
    logic [10:0] r_w;
    logic [15:0] r_sx;
    logic [3:0]  r_log;
    logic [2:0]  r_tr;
    logic [8:0]  r_cy;
    logic [9:0]  r_remh;
    logic [15:0] r_dy;
    logic [8:0]  r_sh;
    logic [7:0]  r_voff;
    logic [8:0]  r_page_y;
    logic [9:0]  r_cx;
    logic [10:0] r_remw;
    logic [15:0] r_dx;

    logic        w_accept;
    logic        w_start;
    logic        w_load;
    logic        w_row_done;
    logic        w_last;
    logic [10:0] w_room_w;
    logic [9:0]  w_room_h;
    logic [10:0] w_w_sat;
    logic [9:0]  w_h_sat;
    logic        w_is_row;
    logic [9:0]  w_pos;
    logic [3:0]  w_log;
    logic [10:0] w_rem;
    t_span       w_span;
    logic [1:0]  w_pix_sh;
    logic [10:0] w_wpix;
    logic [9:0]  w_upix;
    logic [10:0] w_remw_next;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign w_accept = i_valid && !o_stall;
    assign w_start  = w_accept && (i_width_words != 11'd0) && (i_height_lines != 10'd0);

    assign w_room_w = VRAM_WORDS - {1'b0, i_vram_x};
    assign w_room_h = VRAM_LINES - {1'b0, i_vram_y};
    assign w_w_sat  = (i_width_words > w_room_w) ? w_room_w : i_width_words;
    assign w_h_sat  = (i_height_lines > w_room_h) ? w_room_h : i_height_lines;

    assign w_is_row = (r_state == S_ROW);
    assign w_pos    = w_is_row ? {1'b0, r_cy} : r_cx;
    assign w_log    = w_is_row ? LOG_PAGE_LINE : r_log;
    assign w_rem    = w_is_row ? {1'b0, r_remh} : r_remw;

    tpss_span_unit u_span (
        .i_pos  (w_pos),
        .i_log  (w_log),
        .i_rem  (w_rem),
        .o_span (w_span)
    );

    assign w_pix_sh    = 2'(LOG_PAGE_16 - r_log);
    assign w_wpix      = {2'b00, w_span.span} << w_pix_sh;
    assign w_upix      = {2'b00, w_span.off} << w_pix_sh;
    assign w_remw_next = r_remw - {2'b00, w_span.span};
    assign w_row_done  = (w_remw_next == 11'd0);
    assign w_last      = w_row_done && (r_remh == {1'b0, r_sh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = S_COL;
            end
            S_COL: begin
                if (!r_out_valid || !i_stall) begin
                    w_load = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else if (w_row_done) begin
                        n_state = S_ROW;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_vx   <= i_vram_x;
            r_w    <= w_w_sat;
            r_sx   <= i_screen_x;
            r_log  <= f_page_log(i_depth);
            r_tr   <= i_transparency;
            r_cy   <= i_vram_y;
            r_remh <= w_h_sat;
            r_dy   <= i_screen_y;
        end
        if (w_is_row) begin
            r_sh     <= w_span.span;
            r_voff   <= w_span.off;
            r_page_y <= w_span.base[8:0];
            r_cx     <= r_vx;
            r_remw   <= r_w;
            r_dx     <= r_sx;
        end
        if (w_load) begin
            r_cx   <= r_cx + {1'b0, w_span.span};
            r_remw <= w_remw_next;
            r_dx   <= r_dx + {5'b00000, w_wpix};
            if (w_row_done) begin
                r_cy   <= r_cy + r_sh;
                r_remh <= r_remh - {1'b0, r_sh};
                r_dy   <= r_dy + {7'b0000000, r_sh};
            end
            o_draw_x        <= r_dx;
            o_draw_y        <= r_dy;
            o_sprite_width  <= w_wpix[8:0];
            o_sprite_height <= r_sh;
            o_tex_u         <= w_upix[7:0];
            o_tex_v         <= r_voff;
            o_page_x        <= w_span.base;
            o_page_y        <= r_page_y;
            o_blend_mode    <= r_tr[1:0];
            o_semi_trans    <= (r_tr != OPAQUE_MODE);
            o_last          <= w_last;
        end
    end

    a_busy_has_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_remh != 10'd0))
        else $error("busy with no lines left");

    a_col_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (r_remw != 11'd0) && (r_sh != 9'd0))
        else $error("column step with empty span");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE) && o_last)
        else $error("last slice did not end request");

    a_width_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_sprite_width != 9'd0) && (o_sprite_height != 9'd0))
        else $error("empty slice emitted");

endmodule

/* tb/sv/texture_page_sprite_splitter_test.sv */
// Self-checking testbench for texture_page_sprite_splitter: table-driven and random draw
// requests with expected slices from a local predictor or the table, checked per beat.
// Depends on tpss_pkg and the texture_page_sprite_splitter RTL.
module texture_page_sprite_splitter_test;
    import tpss_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [9:0]         vram_x;
        logic [8:0]         vram_y;
        logic [10:0]        width_words;
        logic [9:0]         height_lines;
        logic [1:0]         depth;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic [2:0]         transparency;
    } draw_req_t;

    localparam int REQ_BITS = $bits(draw_req_t);

    typedef struct packed {
        logic signed [15:0] draw_x;
        logic signed [15:0] draw_y;
        logic [8:0]         sprite_width;
        logic [8:0]         sprite_height;
        logic [7:0]         tex_u;
        logic [7:0]         tex_v;
        logic [9:0]         page_x;
        logic [8:0]         page_y;
        logic [1:0]         blend_mode;
        logic               semi_trans;
        logic               last;
    } slice_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_SLICE,
        ONE_SLICE
    } row_kind_e;

    typedef struct packed {
        draw_req_t req;
        row_kind_e kind;
        slice_t    typed;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [20] = '{
        '{'{5, 5, 0, 10, 2, 0, 0, 4}, NO_SLICE, '0},
        '{'{5, 5, 10, 0, 2, 0, 0, 4}, NO_SLICE, '0},
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, NO_SLICE, '0},
        '{'{0, 0, 1, 1, 2, 0, 0, 4}, ONE_SLICE,
          '{0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1}},
        '{'{1023, 511, 2047, 1023, 3, -32768, 32767, 7}, ONE_SLICE,
          '{-32768, 32767, 1, 1, 255, 255, 768, 256, 3, 1, 1}},
        '{'{1023, 0, 1, 1, 0, 32767, -1, 0}, ONE_SLICE,
          '{32767, -1, 4, 1, 252, 0, 960, 0, 0, 1, 1}},
        '{'{1023, 0, 5, 1, 1, 100, 200, 5}, ONE_SLICE,
          '{100, 200, 2, 1, 254, 0, 896, 0, 1, 1, 1}},
        '{'{256, 0, 256, 256, 2, -5, -5, 3}, ONE_SLICE,
          '{-5, -5, 256, 256, 0, 0, 256, 0, 3, 1, 1}},
        '{'{0, 0, 1024, 512, 0, 0, 0, 1}, BY_MODEL, '0},
        '{'{0, 0, 1024, 512, 1, -100, -100, 2}, BY_MODEL, '0},
        '{'{0, 0, 1024, 512, 2, 32000, 32000, 6}, BY_MODEL, '0},
        '{'{0, 0, 1024, 512, 3, -32768, -32768, 4}, BY_MODEL, '0},
        '{'{60, 250, 10, 10, 0, 32760, 32765, 4}, BY_MODEL, '0},
        '{'{120, 100, 20, 300, 1, -1, -1, 3}, BY_MODEL, '0},
        '{'{250, 0, 100, 600, 2, 0, 0, 6}, BY_MODEL, '0},
        '{'{0, 256, 64, 256, 0, 7, 9, 0}, BY_MODEL, '0},
        '{'{900, 400, 2047, 1023, 0, -2, 1000, 2}, BY_MODEL, '0},
        '{'{512, 511, 512, 1, 3, 12345, -12345, 5}, BY_MODEL, '0},
        '{'{0, 0, 1024, 1, 0, 0, 0, 7}, BY_MODEL, '0},
        '{'{63, 255, 2, 2, 0, 1, 1, 4}, BY_MODEL, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [9:0]         i_vram_x;
    logic [8:0]         i_vram_y;
    logic [10:0]        i_width_words;
    logic [9:0]         i_height_lines;
    logic [1:0]         i_depth;
    logic signed [15:0] i_screen_x;
    logic signed [15:0] i_screen_y;
    logic [2:0]         i_transparency;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_draw_x;
    logic signed [15:0] o_draw_y;
    logic [8:0]         o_sprite_width;
    logic [8:0]         o_sprite_height;
    logic [7:0]         o_tex_u;
    logic [7:0]         o_tex_v;
    logic [9:0]         o_page_x;
    logic [8:0]         o_page_y;
    logic [1:0]         o_blend_mode;
    logic               o_semi_trans;
    logic               o_last;

    slice_t pending_slices [$];
    int     mismatch_count;
    int     slice_count;
    bit     hold_output;

    texture_page_sprite_splitter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_vram_x       (i_vram_x),
        .i_vram_y       (i_vram_y),
        .i_width_words  (i_width_words),
        .i_height_lines (i_height_lines),
        .i_depth        (i_depth),
        .i_screen_x     (i_screen_x),
        .i_screen_y     (i_screen_y),
        .i_transparency (i_transparency),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_draw_x       (o_draw_x),
        .o_draw_y       (o_draw_y),
        .o_sprite_width (o_sprite_width),
        .o_sprite_height(o_sprite_height),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_page_x       (o_page_x),
        .o_page_y       (o_page_y),
        .o_blend_mode   (o_blend_mode),
        .o_semi_trans   (o_semi_trans),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void split_into_pages(input draw_req_t r);
        int unsigned w, h, lg, pw, ppw, page_lines;
        int unsigned cy, remh, dy, sh, voff, cx, remw, dx, hoff, sw, n;
        slice_t s, prev;
        bit have_prev;
        w = 32'(r.width_words);
        h = 32'(r.height_lines);
        if (w == 0 || h == 0) return;
        if (w > 32'(VRAM_WORDS) - 32'(r.vram_x)) w = 32'(VRAM_WORDS) - 32'(r.vram_x);
        if (h > 32'(VRAM_LINES) - 32'(r.vram_y)) h = 32'(VRAM_LINES) - 32'(r.vram_y);
        case (r.depth)
            DEPTH_4BIT: begin
                lg = 32'(LOG_PAGE_4BIT);
                ppw = 4;
            end
            DEPTH_8BIT: begin
                lg = 32'(LOG_PAGE_8BIT);
                ppw = 2;
            end
            default: begin
                lg = 32'(LOG_PAGE_16);
                ppw = 1;
            end
        endcase
        pw = 1 << lg;
        page_lines = 1 << LOG_PAGE_LINE;
        have_prev = 1'b0;
        n = 0;
        cy = 32'(r.vram_y);
        remh = h;
        dy = 32'(r.screen_y[15:0]);
        while (remh > 0) begin
            voff = cy & (page_lines - 1);
            sh = page_lines - voff;
            if (sh > remh) sh = remh;
            cx = 32'(r.vram_x);
            remw = w;
            dx = 32'(r.screen_x[15:0]);
            while (remw > 0 && n < 32) begin
                hoff = cx & (pw - 1);
                sw = pw - hoff;
                if (sw > remw) sw = remw;
                s.draw_x        = 16'(dx);
                s.draw_y        = 16'(dy);
                s.sprite_width  = 9'(sw * ppw);
                s.sprite_height = 9'(sh);
                s.tex_u         = 8'(hoff * ppw);
                s.tex_v         = 8'(voff);
                s.page_x        = 10'(cx & ~(pw - 1));
                s.page_y        = 9'(cy & ~(page_lines - 1));
                s.blend_mode    = r.transparency[1:0];
                s.semi_trans    = (r.transparency != OPAQUE_MODE);
                s.last          = 1'b0;
                if (have_prev) pending_slices.push_back(prev);
                prev = s;
                have_prev = 1'b1;
                n++;
                cx += sw;
                remw -= sw;
                dx = (dx + sw * ppw) & 16'hFFFF;
            end
            cy += sh;
            remh -= sh;
            dy = (dy + sh) & 16'hFFFF;
        end
        if (have_prev) begin
            prev.last = 1'b1;
            pending_slices.push_back(prev);
        end
    endfunction

    function automatic draw_req_t random_request();
        draw_req_t r;
        int unsigned pick, span;
        r = REQ_BITS'({$urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 5) begin
            if ($urandom_range(1)) r.width_words = '0;
            else r.height_lines = '0;
        end else if (pick >= 15) begin
            r.vram_x = 10'($urandom_range(1023));
            r.vram_y = 9'($urandom_range(511));
            if (pick < 30) begin
                r.width_words  = 11'($urandom_range(1024 - r.vram_x, 1));
                r.height_lines = 10'($urandom_range(512 - r.vram_y, 1));
            end else begin
                if ($urandom_range(1)) r.vram_x = 10'($urandom_range(15) * 64 + 64
                                                      - $urandom_range(6, 1));
                if ($urandom_range(2) == 0) r.vram_y = 9'(256 - $urandom_range(6, 1));
                span = 1024 - r.vram_x;
                r.width_words = 11'($urandom_range(span < 48 ? span : 48, 1));
                span = 512 - r.vram_y;
                r.height_lines = 10'($urandom_range(span < 48 ? span : 48, 1));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("ERROR: %s", what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("slice %0d %s: got %0h expected %0h",
                                      slice_count, name, got, want));
    endtask

    task automatic put_fields(input draw_req_t r);
        i_vram_x       <= r.vram_x;
        i_vram_y       <= r.vram_y;
        i_width_words  <= r.width_words;
        i_height_lines <= r.height_lines;
        i_depth        <= r.depth;
        i_screen_x     <= r.screen_x;
        i_screen_y     <= r.screen_y;
        i_transparency <= r.transparency;
    endtask

    task automatic offer_request(input draw_req_t r, input row_kind_e kind,
                                 input slice_t typed);
        i_valid <= 1'b1;
        put_fields(r);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (kind == BY_MODEL) split_into_pages(r);
        else if (kind == ONE_SLICE) pending_slices.push_back(typed);
        @(negedge i_clk);
    endtask

    task automatic idle(input int cycles);
        i_valid <= 1'b0;
        put_fields(random_request());
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_slices();
        idle(1);
        while (pending_slices.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : slice_monitor
        slice_t got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_draw_x, o_draw_y, o_sprite_width, o_sprite_height, o_tex_u, o_tex_v,
                   o_page_x, o_page_y, o_blend_mode, o_semi_trans, o_last};
            if (pending_slices.size() == 0) begin
                report_mismatch($sformatf("unexpected slice at x=%0d y=%0d",
                                          got.draw_x, got.draw_y));
            end else begin
                want = pending_slices.pop_front();
                check_field("draw_x", got.draw_x, want.draw_x);
                check_field("draw_y", got.draw_y, want.draw_y);
                check_field("sprite_width", 16'(got.sprite_width),
                            16'(want.sprite_width));
                check_field("sprite_height", 16'(got.sprite_height),
                            16'(want.sprite_height));
                check_field("tex_u", 16'(got.tex_u), 16'(want.tex_u));
                check_field("tex_v", 16'(got.tex_v), 16'(want.tex_v));
                check_field("page_x", 16'(got.page_x), 16'(want.page_x));
                check_field("page_y", 16'(got.page_y), 16'(want.page_y));
                check_field("blend_mode", 16'(got.blend_mode), 16'(want.blend_mode));
                check_field("semi_trans", 16'(got.semi_trans), 16'(want.semi_trans));
                check_field("last", 16'(got.last), 16'(want.last));
            end
            slice_count++;
        end
    end

    initial begin : output_stall
        int stall_pct, mode_left, hold_left;
        stall_pct = 0;
        mode_left = 0;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_output) begin
                hold_output = 1'b0;
                hold_left = 300;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    mode_left = $urandom_range(150, 30);
                end
                mode_left--;
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("texture_page_sprite_splitter_test failed");
        $finish;
    end

    initial begin : stimulus
        int burst_left;
        mismatch_count = 0;
        slice_count = 0;
        hold_output = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_vram_x = '0;
        i_vram_y = '0;
        i_width_words = '0;
        i_height_lines = '0;
        i_depth = '0;
        i_screen_x = '0;
        i_screen_y = '0;
        i_transparency = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle(1);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].kind,
                          DIRECTED_ROWS[i].typed);
            if ($urandom_range(3) == 0) idle($urandom_range(4, 1));
        end
        drain_slices();

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) begin
                // hold the output while requests keep coming
                hold_output = 1'b1;
                burst_left = 40;
            end else if (n == 260) begin
                drain_slices();
                burst_left = $urandom_range(8, 1);
            end
            if (burst_left == 0) begin
                idle($urandom_range(12, 1));
                burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(8, 1);
            end
            burst_left--;
            offer_request(random_request(), BY_MODEL, '0);
        end
        drain_slices();
        repeat (40) @(negedge i_clk);

        if (mismatch_count == 0) $display("texture_page_sprite_splitter_test passed");
        else $display("texture_page_sprite_splitter_test failed");
        $finish;
    end

endmodule

/* files.f */
design/tpss_pkg.sv
design/tpss_span_unit.sv
design/texture_page_sprite_splitter.sv
tb/sv/texture_page_sprite_splitter_test.sv
